[rtl/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg - shared types and constants of the table linear interpolator
// Field widths, status and opcode codes, register map and the queue item.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  // table depth default
  localparam int MAX_POINTS_DEF = 32;

  // payload widths
  localparam int VAL_W       = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  // input tdata field offsets
  localparam int IDX_LSB = 0;
  localparam int EX_LSB  = 5;
  localparam int EY_LSB  = 37;
  localparam int QX_LSB  = 69;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] PC_RESET = 6'd2;
  localparam logic [CNT_W-1:0] PC_MIN   = 6'd2;

  // slope divider and product widths
  localparam int NUM_W  = 49;
  localparam int DEN_W  = 33;
  localparam int PROD_W = 65;
  localparam int SUM_W  = 50;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EQX = 2'd2;

  // classified request held in the queue between front and back
  typedef struct packed {
    logic             is_query;
    logic             wr_ok;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } item_t;

endpackage

`default_nettype wire

[rtl/table_linear_interpolator_top.sv]
// ----------------------------------------------------------------------------
// table_linear_interpolator_top - piecewise linear table interpolator
// Stream in table writes and queries, stream out interpolated Q16.16 values.
// ----------------------------------------------------------------------------
// Write request: retired in the same cycle it reaches the back end, one per cycle while no
//   query is in flight, no result. Query: a nearest search over the N entries in use reads
//   one entry per cycle; an exact hit then returns the entry, equal abscissas return zero,
//   else the 49-step serial slope divider interpolates. One query in flight at a time.
// Reset clears all control state and sets point_count to 2; table contents
//   stay undefined until written.
`default_nettype none

module table_linear_interpolator_top #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [4:0] entry_index, [36:5] entry_x, [68:37] entry_y, [100:69] query_x, pad
  input  wire logic [tli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  wire logic [tli_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] result_y
  output logic      [tli_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic      [tli_pkg::OUT_TUSER_W-1:0] out_tuser,
  // configuration port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tli_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [tli_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic      [tli_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [tli_pkg::CNT_W-1:0] pc_r;
  logic                      cfg_wr;
  logic                      head_valid;
  tli_pkg::item_t            head;
  logic                      pop;

  // point_count register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == tli_pkg::REG_POINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tli_pkg::PC_RESET;
    end else if (cfg_wr) begin
      pc_r <= cfg_pwdata[tli_pkg::CNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tli_pkg::REG_POINT_COUNT) ?
                      tli_pkg::DATA_W'(pc_r) : '0;

  tli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_count  (pc_r),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_result_y (out_tdata),
    .out_status   (out_tuser)
  );

endmodule

`default_nettype wire

[rtl/tli_ram.sv]
// ----------------------------------------------------------------------------
// tli_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/tli_front.sv]
// ----------------------------------------------------------------------------
// tli_front - request intake and classification
// Unpacks the input stream, flags writes beyond the table, two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_front #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tli_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [tli_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                                head_valid,
  output tli_pkg::item_t                      head,
  input  wire logic                           pop
);

  tli_pkg::item_t           item;
  tli_pkg::item_t           slot_r [2];
  logic [1:0]               count_r;
  logic                     wptr_r;
  logic                     rptr_r;
  logic                     push;
  logic [tli_pkg::IDX_W-1:0] idx;

  // classify the incoming request
  assign idx = in_tdata[tli_pkg::IDX_LSB +: tli_pkg::IDX_W];

  always_comb begin
    item.is_query = (in_tuser[0] == tli_pkg::OP_QUERY);
    item.wr_ok    = (32'(idx) < 32'(MAX_POINTS));
    item.idx      = idx;
    if (in_tuser[0] == tli_pkg::OP_QUERY) begin
      item.a = in_tdata[tli_pkg::QX_LSB +: tli_pkg::VAL_W];
      item.b = '0;
    end else begin
      item.a = in_tdata[tli_pkg::EX_LSB +: tli_pkg::VAL_W];
      item.b = in_tdata[tli_pkg::EY_LSB +: tli_pkg::VAL_W];
    end
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/tli_div.sv]
// ----------------------------------------------------------------------------
// tli_div - serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tli_pkg::NUM_W-1:0] num,
  input  wire logic [tli_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [tli_pkg::NUM_W-1:0] quot
);

  localparam int NUM_W = tli_pkg::NUM_W;
  localparam int DEN_W = tli_pkg::DEN_W;
  localparam int CW    = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  assign done = done_r;
  assign quot = num_r;

  // datapath: dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tli_back.sv]
// ----------------------------------------------------------------------------
// tli_back - table store, nearest search and interpolation
// Writes entries, scans for the nearest abscissa, divides, multiplies, adds.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_back #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [tli_pkg::CNT_W-1:0]  point_count,
  input  wire logic                       head_valid,
  input  wire tli_pkg::item_t             head,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [tli_pkg::VAL_W-1:0]  out_result_y,
  output logic      [tli_pkg::STAT_W-1:0] out_status
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int VAL_W  = tli_pkg::VAL_W;
  localparam int NUM_W  = tli_pkg::NUM_W;
  localparam int DEN_W  = tli_pkg::DEN_W;
  localparam int PROD_W = tli_pkg::PROD_W;
  localparam int SUM_W  = tli_pkg::SUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_RDP  = 4'd3;
  localparam logic [3:0] S_RDW  = 4'd4;
  localparam logic [3:0] S_CALC = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SLP  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_HIT  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // control state
  logic [3:0]  state_r, state_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic        iss_done_r, iss_done_nxt;
  logic        cv_r, cv_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath registers
  logic [AW-1:0]       ci_r, ci_nxt;
  logic [AW-1:0]       best_r, best_nxt;
  logic [AW-1:0]       pp_r, pp_nxt;
  logic [DEN_W-1:0]    bestd_r, bestd_nxt;
  logic [VAL_W-1:0]    bestx_r, bestx_nxt;
  logic [VAL_W-1:0]    q_r, q_nxt;
  logic [VAL_W-1:0]    xm_r, xm_nxt;
  logic [VAL_W-1:0]    ym_r, ym_nxt;
  logic [VAL_W-1:0]    xp_r, xp_nxt;
  logic [VAL_W-1:0]    yp_r, yp_nxt;
  logic signed [DEN_W-1:0]  qd_r, qd_nxt;
  logic                neg_r, neg_nxt;
  logic signed [VAL_W-1:0]  slope_r, slope_nxt;
  logic                ssat_r, ssat_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [VAL_W-1:0]    res_r, res_nxt;
  logic [tli_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [VAL_W-1:0]    out_y_r, out_y_nxt;
  logic [tli_pkg::STAT_W-1:0] out_st_r, out_st_nxt;

  // combinational helpers
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    pp_sel;
  logic [VAL_W-1:0] xrd;
  logic [VAL_W-1:0] yrd;
  logic             we;
  logic [DEN_W-1:0] dq;
  logic [DEN_W-1:0] absd;
  logic [DEN_W-1:0] dx;
  logic [DEN_W-1:0] dy;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] qmag;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum;
  logic             sum_ovf;
  logic             slope_ovf;

  // entries in use, clamped to the table
  always_comb begin
    if (point_count < tli_pkg::PC_MIN) begin
      last_idx = AW'(1);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(point_count - 1'b1);
    end
  end

  // table memories
  assign we = pop && !head.is_query && head.wr_ok;

  tli_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_xram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(head.idx)),
    .wdata (head.a),
    .raddr (raddr),
    .rdata (xrd)
  );

  tli_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_yram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(head.idx)),
    .wdata (head.b),
    .raddr (raddr),
    .rdata (yrd)
  );

  // distance of the scanned entry
  assign dq   = {q_r[VAL_W-1], q_r} - {xrd[VAL_W-1], xrd};
  assign absd = dq[DEN_W-1] ? (~dq + 1'b1) : dq;

  // pair selection around the nearest entry
  always_comb begin
    if ($signed(q_r) < $signed(bestx_r)) begin
      pp_sel = (best_r == '0) ? AW'(1) : best_r;
    end else begin
      pp_sel = (best_r == last_idx) ? last_idx : best_r + 1'b1;
    end
  end

  // pair differences
  assign dx = {xp_r[VAL_W-1], xp_r} - {xm_r[VAL_W-1], xm_r};
  assign dy = {yp_r[VAL_W-1], yp_r} - {ym_r[VAL_W-1], ym_r};
  assign div_num = {(dy[DEN_W-1] ? (~dy + 1'b1) : dy), 16'd0};
  assign div_den = dx[DEN_W-1] ? (~dx + 1'b1) : dx;

  tli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (qmag)
  );

  // slope saturation
  always_comb begin
    if (neg_r) begin
      slope_ovf = (|qmag[NUM_W-1:32]) || (qmag[31] && (|qmag[30:0]));
    end else begin
      slope_ovf = |qmag[NUM_W-1:31];
    end
  end

  // floor shift of the product and final sum
  assign prod_sh = prod_r >>> 16;
  assign sum     = SUM_W'($signed(ym_r)) + SUM_W'($signed(prod_sh[NUM_W-1:0]));
  assign sum_ovf = !((&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    iss_done_nxt  = iss_done_r;
    cv_nxt        = 1'b0;
    ci_nxt        = ci_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    bestx_nxt     = bestx_r;
    pp_nxt        = pp_r;
    q_nxt         = q_r;
    xm_nxt        = xm_r;
    ym_nxt        = ym_r;
    xp_nxt        = xp_r;
    yp_nxt        = yp_r;
    qd_nxt        = qd_r;
    neg_nxt       = neg_r;
    slope_nxt     = slope_r;
    ssat_nxt      = ssat_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_y_nxt     = out_y_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    raddr         = scan_r;
    pop           = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.is_query) begin
            q_nxt        = head.a;
            scan_nxt     = '0;
            iss_done_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read per cycle, compare the one before
        if (!iss_done_r) begin
          cv_nxt   = 1'b1;
          ci_nxt   = scan_r;
          scan_nxt = scan_r + 1'b1;
          if (scan_r == last_idx) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (cv_r) begin
          if ((ci_r == '0) || (absd < bestd_r)) begin
            best_nxt  = ci_r;
            bestd_nxt = absd;
            bestx_nxt = xrd;
          end
          if (ci_r == last_idx) begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (q_r == bestx_r) begin
          raddr     = best_r;
          state_nxt = S_HIT;
        end else begin
          raddr     = pp_sel - 1'b1;
          pp_nxt    = pp_sel;
          state_nxt = S_RDP;
        end
      end
      S_HIT: begin
        res_nxt   = yrd;
        stat_nxt  = tli_pkg::ST_OK;
        state_nxt = S_OUT;
      end
      S_RDP: begin
        raddr     = pp_r;
        xm_nxt    = xrd;
        ym_nxt    = yrd;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        xp_nxt    = xrd;
        yp_nxt    = yrd;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        qd_nxt  = $signed({q_r[VAL_W-1], q_r} - {xm_r[VAL_W-1], xm_r});
        neg_nxt = dx[DEN_W-1] ^ dy[DEN_W-1];
        if (dx == '0) begin
          res_nxt   = '0;
          stat_nxt  = tli_pkg::ST_EQX;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SLP;
        end
      end
      S_SLP: begin
        ssat_nxt = slope_ovf;
        if (slope_ovf) begin
          slope_nxt = neg_r ? $signed({1'b1, {(VAL_W-1){1'b0}}})
                            : $signed({1'b0, {(VAL_W-1){1'b1}}});
        end else begin
          slope_nxt = neg_r ? $signed(~qmag[VAL_W-1:0] + 1'b1) : $signed(qmag[VAL_W-1:0]);
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(slope_r) * PROD_W'(qd_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (sum_ovf) begin
          res_nxt = sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          res_nxt = sum[VAL_W-1:0];
        end
        stat_nxt  = (sum_ovf || ssat_r) ? tli_pkg::ST_SAT : tli_pkg::ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_y_nxt     = res_r;
          out_st_nxt    = stat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      iss_done_r  <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      iss_done_r  <= iss_done_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ci_r     <= ci_nxt;
    best_r   <= best_nxt;
    bestd_r  <= bestd_nxt;
    bestx_r  <= bestx_nxt;
    pp_r     <= pp_nxt;
    q_r      <= q_nxt;
    xm_r     <= xm_nxt;
    ym_r     <= ym_nxt;
    xp_r     <= xp_nxt;
    yp_r     <= yp_nxt;
    qd_r     <= qd_nxt;
    neg_r    <= neg_nxt;
    slope_r  <= slope_nxt;
    ssat_r   <= ssat_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
    stat_r   <= stat_nxt;
    out_y_r  <= out_y_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_result_y = out_y_r;
  assign out_status   = out_st_r;

endmodule

`default_nettype wire

[rtl/tli_checker.sv]
// ----------------------------------------------------------------------------
// tli_checker - port-level checks of the table linear interpolator
// Output hold, status coding, error result and register read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tli_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [tli_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                            cfg_psel,
  input wire logic                            cfg_penable,
  input wire logic                            cfg_pwrite,
  input wire logic [tli_pkg::ADDR_W-1:0]      cfg_paddr,
  input wire logic [tli_pkg::DATA_W-1:0]      cfg_pwdata,
  input wire logic [tli_pkg::DATA_W-1:0]      cfg_prdata,
  input wire logic                            cfg_pready
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == tli_pkg::ST_OK) || (out_tuser == tli_pkg::ST_SAT)
                   || (out_tuser == tli_pkg::ST_EQX))
    else $error("undefined status code");

  // equal abscissas give a zero result
  a_eqx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tli_pkg::ST_EQX) |-> (out_tdata == '0))
    else $error("non-zero result with equal abscissas");

  // a register write shows on the next read-back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
    && (cfg_paddr[2] == tli_pkg::REG_POINT_COUNT)
    |=> (cfg_paddr[2] != tli_pkg::REG_POINT_COUNT)
        || (cfg_prdata == tli_pkg::DATA_W'($past(cfg_pwdata[tli_pkg::CNT_W-1:0]))))
    else $error("point_count read-back mismatch");

endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (.*);

`default_nettype wire

[tb/tb_table_linear_interpolator_top.sv]
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator_top - table linear interpolator testbench
// Streams table writes and queries into the block under random burst gaps and
// result stalls. A local model of the table predicts every query result, and
// each result is checked in order against it. Covers the reset point count,
// directed corner queries, then random tables under several point counts,
// the out-of-range settings included.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tli_pkg::*;

  // one predicted result: value and status
  typedef struct packed {
    logic [VAL_W-1:0]  y;
    logic [STAT_W-1:0] status;
  } interp_result_t;

  localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
  localparam int DRAIN_CYCLES = 128;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam logic [ADDR_W-1:0] POINT_COUNT_ADDR = ADDR_W'(4 * int'(REG_POINT_COUNT));

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input stream
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;

  // result stream
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // configuration port
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the table and the point count register
  logic signed [VAL_W-1:0] table_x [TABLE_DEPTH];
  logic signed [VAL_W-1:0] table_y [TABLE_DEPTH];
  logic [CNT_W-1:0]        point_count_cfg = PC_RESET;

  // predicted results still to arrive, oldest first
  interp_result_t pending_results [$];

  int error_count   = 0;
  int write_count   = 0;
  int query_count   = 0;
  int result_count  = 0;
  int setting_count = 0;
  int burst_left    = 0;
  logic [31:0] ready_tick = '0;

  table_linear_interpolator_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(64'd10_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("table_linear_interpolator_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("%0t ns MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // entries a query actually searches for a given register value
  function automatic int entries_in_use(logic [CNT_W-1:0] count);
    if (count < PC_MIN)
      return int'(PC_MIN);
    if (count > TABLE_DEPTH)
      return TABLE_DEPTH;
    return int'(count);
  endfunction

  // nearest-entry search, then hit, equal-x, or interpolate/extrapolate
  function automatic interp_result_t interpolate_query(logic signed [VAL_W-1:0] qx);
    int n, i, best, pp, pm;
    longint q, d, best_d, dx, dy, slope, acc;
    logic sat;
    interp_result_t r;
    n = entries_in_use(point_count_cfg);
    q = qx;
    best = 0;
    best_d = q - table_x[0];
    if (best_d < 0) best_d = -best_d;
    for (i = 1; i < n; i++) begin
      d = q - table_x[i];
      if (d < 0) d = -d;
      // strict compare keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (q == table_x[best]) begin
      r.y = table_y[best];
      r.status = ST_OK;
      return r;
    end
    // pick the pair on the query's side, clamped to the ends
    if (q < table_x[best])
      pp = (best == 0) ? 1 : best;
    else
      pp = (best == n - 1) ? n - 1 : best + 1;
    pm = pp - 1;
    dx = longint'(table_x[pp]) - longint'(table_x[pm]);
    if (dx == 0) begin
      r.y = '0;
      r.status = ST_EQX;
      return r;
    end
    dy = longint'(table_y[pp]) - longint'(table_y[pm]);
    sat = 1'b0;
    slope = (dy * 65536) / dx;
    if (slope > S32_MAX) begin
      slope = S32_MAX;
      sat = 1'b1;
    end else if (slope < S32_MIN) begin
      slope = S32_MIN;
      sat = 1'b1;
    end
    // arithmetic shift gives the floor of the Q16.16 product
    acc = longint'(table_y[pm]) + ((slope * (q - table_x[pm])) >>> 16);
    if (acc > S32_MAX) begin
      acc = S32_MAX;
      sat = 1'b1;
    end else if (acc < S32_MIN) begin
      acc = S32_MIN;
      sat = 1'b1;
    end
    r.y = VAL_W'(acc);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // one request on the input stream, with burst and gap pacing
  task automatic send_request(logic op, logic [IDX_W-1:0] idx,
                              logic signed [VAL_W-1:0] ex, logic signed [VAL_W-1:0] ey,
                              logic signed [VAL_W-1:0] qx);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({qx, ey, ex, idx});
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      table_x[idx] = ex;
      table_y[idx] = ey;
      write_count++;
    end else begin
      pending_results.push_back(interpolate_query(qx));
      query_count++;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) > 6) ? $urandom_range(3, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // unused fields carry random junk
  task automatic send_write(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] x,
                            logic signed [VAL_W-1:0] y);
    send_request(OP_WRITE, idx, x, y, $urandom);
  endtask

  task automatic send_query(logic signed [VAL_W-1:0] q);
    send_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, q);
  endtask

  // stop sending and let the block drain completely
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one APB transfer; psel is left high for a following transfer
  task automatic cfg_transfer(logic wr, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= POINT_COUNT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic check_point_count(logic [DATA_W-1:0] rd);
    if (rd !== DATA_W'(point_count_cfg))
      report_mismatch($sformatf("point_count read 0x%0h, want 0x%0h", rd, point_count_cfg));
  endtask

  // write the point count, then read it back
  task automatic program_point_count(logic [CNT_W-1:0] value);
    logic [DATA_W-1:0] rd;
    cfg_transfer(1'b1, DATA_W'(value), rd);
    point_count_cfg = value;
    setting_count++;
    cfg_transfer(1'b0, '0, rd);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_point_count(rd);
  endtask

  // ---------------------------------------------------------------------------
  // result checking and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    interp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=0x%08h status=%0d",
                                  out_tdata, out_tuser));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.y)
          report_mismatch($sformatf("result %0d: y 0x%08h, want 0x%08h",
                                    result_count, out_tdata, want.y));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                    result_count, out_tuser, want.status));
      end
    end
    // stall modes rotate: always ready, coin toss, rare ready, mostly ready
    ready_tick <= ready_tick + 1;
    case (ready_tick[8:7])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (ready_tick[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 6) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset point count of two: hits, tie, both ends, saturation, equal x
  task automatic test_reset_point_count();
    logic [DATA_W-1:0] rd;
    cfg_transfer(1'b0, '0, rd);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_point_count(rd);

    send_write(0, 32'sh0000_0000, 32'sh0000_0000);
    send_write(1, 32'sh0001_0000, 32'sh0002_0000);
    send_query(32'sh0000_0000);            // hit on entry 0
    send_query(32'sh0000_8000);            // tie, interpolates
    send_query(32'sh0001_8000);            // past the last entry
    send_query(32'shFFFF_0000);            // before the first entry
    send_query(32'sh7FFF_FFFF);            // result saturates high
    send_query(32'sh8000_0000);            // result saturates low

    // equal abscissas in the pair
    send_write(1, 32'sh0000_0000, 32'sh0001_2345);
    send_query(32'sh0002_0000);
    send_query(32'sh0000_0000);

    // slope saturates
    send_write(0, 32'sh0000_0000, 32'sh8000_0000);
    send_write(1, 32'sh0000_0001, 32'sh7FFF_FFFF);
    send_query(32'sh0000_0003);

    // full-scale falling pair, floor rounding of a negative product
    send_write(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_write(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_query(32'sh0000_0000);
    send_query(32'sh8000_0000);
    send_write(31, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
  endtask

  // four entries with negative coordinates
  task automatic test_point_count_four();
    wait_quiet();
    program_point_count(6'd4);
    send_write(0, 32'shFFFD_0000, 32'sh0001_8000);
    send_write(1, 32'shFFFF_0000, 32'shFFFF_C000);
    send_write(2, 32'sh0002_0000, 32'sh0004_0000);
    send_write(3, 32'sh0002_8000, 32'sh0004_0000);
    send_query(32'shFFFF_0000);            // hit
    send_query(32'sh0000_8000);            // tie between 1 and 2
    send_query(32'sh0002_6666);            // left of the nearest entry
    send_query(32'sh000A_0000);            // flat extrapolation
  endtask

  // rewrite the first entries as an evenly spaced table
  task automatic load_grid(int count);
    logic signed [VAL_W-1:0] x, y, step;
    int i;
    x = $signed($urandom) >>> $urandom_range(2, 10);
    step = $urandom_range(1, 1 << $urandom_range(4, 22));
    if ($urandom_range(0, 3) == 0) step = -step;
    y = $signed($urandom) >>> $urandom_range(4, 12);
    for (i = 0; i < count; i++) begin
      send_write(IDX_W'(i), x, y);
      x = x + step;
      y = y + ($signed($urandom) >>> $urandom_range(6, 20));
    end
  endtask

  // mostly queries around the table, some writes that perturb it
  task automatic run_mixed(int items, int used);
    int k, j, kind;
    logic [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] q, x, y;
    for (k = 0; k < items; k++) begin
      kind = $urandom_range(0, 9);
      j = $urandom_range(0, used - 1);
      if ($urandom_range(0, 9) < 6) begin
        case (kind)
          4: q = table_x[j];
          5: q = (j < used - 1) ?
                 VAL_W'((longint'(table_x[j]) + longint'(table_x[j+1])) >>> 1) : table_x[j];
          6: q = $urandom;
          7: q = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: q = table_x[j] + ($signed($urandom) >>> $urandom_range(8, 28));
        endcase
        send_query(q);
      end else begin
        idx = IDX_W'(j);
        case (kind)
          6: begin
            // copy a neighbour's x to build an equal-x pair
            x = table_x[(j == 0) ? 1 : j - 1];
            y = $urandom;
          end
          7, 8: begin
            idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            x = $urandom;
            y = $urandom;
          end
          9: begin
            x = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            y = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          end
          default: begin
            x = table_x[j] + ($signed($urandom) >>> $urandom_range(12, 24));
            y = table_y[j] + ($signed($urandom) >>> $urandom_range(10, 24));
          end
        endcase
        send_write(idx, x, y);
      end
    end
  endtask

  // random tables under a range of point counts, out-of-range ones too
  task automatic test_random_tables();
    int counts [11] = '{32, 5, 0, 63, 1, 17, 33, 2, 32, 9, 31};
    int p, used;
    logic [CNT_W-1:0] count;
    for (p = 0; p < 13; p++) begin
      count = (p < 11) ? CNT_W'(counts[p]) : CNT_W'($urandom_range(3, 31));
      wait_quiet();
      program_point_count(count);
      used = entries_in_use(count);
      // first pass fills the whole table so no query sees an unwritten entry
      load_grid((p == 0) ? TABLE_DEPTH : used);
      run_mixed(24, used);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_point_count();
    test_point_count_four();
    test_random_tables();
    wait_quiet();
    $display("Sent %0d table writes and %0d queries; checked %0d results",
             write_count, query_count, result_count);
    $display("Point count programmed %0d times, extremes and out-of-range values included",
             setting_count);
    if (error_count == 0) begin
      $display("table_linear_interpolator_top verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("table_linear_interpolator_top verification failed");
    end
    $finish;
  end

endmodule
